@@ hdl/mse_pkg.sv @@
// Shared sizes and controller/datapath interface types for the merge sort engine.
// Depends on nothing; mse_ctrl, mse_datapath and merge_sort_engine import it.
`default_nettype none
package mse_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int EXT_W      = CNT_W + 1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // store the incoming value
        logic mark_sorted;  // the current set counts as sorted from now on
        logic sort_start;   // run width 1, first pair at index 0
        logic pair_setup;   // compute the bounds of the current run pair
        logic merge_step;   // move one element into the destination buffer
        logic pair_next;    // advance to the next run pair
        logic pass_next;    // swap buffers, double the run width
        logic rd_addr;      // address the store at the read position
        logic out_load;     // capture a result into the output register
    } mse_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sorted;
        logic count_le1;
        logic pair_last;
        logic lo_end;
        logic width_end;
        logic out_free;
    } mse_status_t;

endpackage
`default_nettype wire

@@ hdl/mse_ram.sv @@
// Generic simple RAM: one write port, two read ports with registered data.
// Depends on nothing.
`default_nettype none
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata0,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule
`default_nettype wire

@@ hdl/mse_ctrl.sv @@
// Sequencing state machine of the merge sort engine.
// Depends on mse_pkg for the command and status structs.
`default_nettype none
module mse_ctrl
    import mse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tuser,
    output logic             s_tready,
    output mse_cmd_t         cmd,
    input  wire mse_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MERGE,
        ST_NEXT,
        ST_RD_ISSUE,
        ST_RD_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   accept;

    assign accept   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!s_tuser)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (status.sorted)
                    begin
                        state_next = ST_RD_ISSUE;
                    end
                    else
                    begin
                        cmd.mark_sorted = 1'b1;
                        if (status.count_le1)
                        begin
                            state_next = ST_RD_ISSUE;
                        end
                        else
                        begin
                            cmd.sort_start = 1'b1;
                            state_next     = ST_SETUP;
                        end
                    end
                end
            end
            ST_SETUP:
            begin
                cmd.pair_setup = 1'b1;
                state_next     = ST_MERGE;
            end
            ST_MERGE:
            begin
                cmd.merge_step = 1'b1;
                if (status.pair_last)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (status.lo_end)
                begin
                    cmd.pass_next = 1'b1;
                    state_next    = status.width_end ? ST_RD_ISSUE : ST_SETUP;
                end
                else
                begin
                    cmd.pair_next = 1'b1;
                    state_next    = ST_SETUP;
                end
            end
            ST_RD_ISSUE:
            begin
                cmd.rd_addr = 1'b1;
                state_next  = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                // The read address is held so the registered data stays put while stalled.
                cmd.rd_addr = 1'b1;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule
`default_nettype wire

@@ hdl/mse_datapath.sv @@
// Datapath of the merge sort engine: ping-pong element buffers, merge pointers,
// set counters and the output register. Depends on mse_pkg and mse_ram.
`default_nettype none
module mse_datapath
    import mse_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [DATA_WIDTH-1:0] in_value,
    input  wire mse_cmd_t              cmd,
    output mse_status_t                status,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic      [DATA_WIDTH-1:0] m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);

    // Control state, cleared by reset.
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rdpos_reg, rdpos_next;
    logic             sorted_reg, sorted_next;
    logic             sel_reg, sel_next;
    logic             out_valid_reg, out_valid_next;

    // Merge pointers and output payload.
    logic [CNT_W-1:0]      width_reg, width_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      mid_reg, mid_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [CNT_W-1:0]      i_reg, i_next;
    logic [CNT_W-1:0]      j_reg, j_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [DATA_WIDTH-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_err_reg, out_err_next;

    logic [EXT_W-1:0]      count_ext;
    logic [EXT_W-1:0]      lo_w;
    logic [EXT_W-1:0]      lo_2w;
    logic [EXT_W-1:0]      width_2x;
    logic [CNT_W-1:0]      mid_calc;
    logic [CNT_W-1:0]      hi_calc;

    logic [DATA_WIDTH-1:0] rdata0_a, rdata1_a, rdata0_b, rdata1_b;
    logic [DATA_WIDTH-1:0] src_a, src_b;
    logic [DATA_WIDTH-1:0] merge_data;
    logic                  take_left;
    logic                  load_ok;
    logic [ADDR_W-1:0]     load_addr;
    logic                  rd_empty;

    logic                  we_a, we_b;
    logic [ADDR_W-1:0]     waddr_a;
    logic [DATA_WIDTH-1:0] wdata_a;
    logic [ADDR_W-1:0]     raddr0, raddr1;

    assign count_ext = {1'b0, count_reg};
    assign lo_w      = {1'b0, lo_reg} + {1'b0, width_reg};
    assign width_2x  = {width_reg, 1'b0};
    assign lo_2w     = {1'b0, lo_reg} + width_2x;
    assign mid_calc  = (lo_w >= count_ext) ? count_reg : lo_w[CNT_W-1:0];
    assign hi_calc   = (lo_2w >= count_ext) ? count_reg : lo_2w[CNT_W-1:0];

    // Both buffers are read at the same addresses; sel_reg names the source.
    assign src_a = sel_reg ? rdata0_b : rdata0_a;
    assign src_b = sel_reg ? rdata1_b : rdata1_a;

    // The left run wins ties, so equal keys keep their load order.
    assign take_left  = (i_reg < mid_reg) &&
                        (!(j_reg < hi_reg) || ($signed(src_a) <= $signed(src_b)));
    assign merge_data = take_left ? src_a : src_b;

    assign load_ok   = sorted_reg || (count_reg < CNT_W'(DEPTH));
    assign load_addr = sorted_reg ? '0 : count_reg[ADDR_W-1:0];
    assign rd_empty  = (rdpos_reg >= count_reg);

    assign we_a    = cmd.load ? load_ok : (cmd.merge_step && sel_reg);
    assign waddr_a = cmd.load ? load_addr : k_reg[ADDR_W-1:0];
    assign wdata_a = cmd.load ? in_value : merge_data;
    assign we_b    = cmd.merge_step && !sel_reg;
    assign raddr0  = cmd.rd_addr ? rdpos_reg[ADDR_W-1:0] : i_next[ADDR_W-1:0];
    assign raddr1  = j_next[ADDR_W-1:0];

    always_comb
    begin
        count_next     = count_reg;
        rdpos_next     = rdpos_reg;
        sorted_next    = sorted_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        if (cmd.load)
        begin
            sel_next = 1'b0;
            if (sorted_reg)
            begin
                // A load after a read starts a new set.
                count_next  = CNT_W'(1);
                rdpos_next  = '0;
                sorted_next = 1'b0;
            end
            else if (load_ok)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.mark_sorted)
        begin
            sorted_next = 1'b1;
        end
        if (cmd.sort_start)
        begin
            width_next = CNT_W'(1);
            lo_next    = '0;
        end
        if (cmd.pair_setup)
        begin
            mid_next = mid_calc;
            hi_next  = hi_calc;
            i_next   = lo_reg;
            j_next   = mid_calc;
            k_next   = lo_reg;
        end
        if (cmd.merge_step)
        begin
            if (take_left)
            begin
                i_next = i_reg + CNT_W'(1);
            end
            else
            begin
                j_next = j_reg + CNT_W'(1);
            end
            k_next = k_reg + CNT_W'(1);
        end
        if (cmd.pair_next)
        begin
            lo_next = lo_2w[CNT_W-1:0];
        end
        if (cmd.pass_next)
        begin
            sel_next   = !sel_reg;
            width_next = width_2x[CNT_W-1:0];
            lo_next    = '0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            if (rd_empty)
            begin
                out_data_next = '0;
                out_last_next = 1'b0;
                out_err_next  = 1'b1;
            end
            else
            begin
                out_data_next = src_a;
                out_last_next = ((rdpos_reg + CNT_W'(1)) == count_reg);
                out_err_next  = 1'b0;
                rdpos_next    = rdpos_reg + CNT_W'(1);
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rdpos_reg     <= '0;
            sorted_reg    <= 1'b0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rdpos_reg     <= rdpos_next;
            sorted_reg    <= sorted_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg    <= width_next;
        lo_reg       <= lo_next;
        mid_reg      <= mid_next;
        hi_reg       <= hi_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    mse_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_buf_a (
        .clk    (clk),
        .we     (we_a),
        .waddr  (waddr_a),
        .wdata  (wdata_a),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0_a),
        .rdata1 (rdata1_a)
    );

    mse_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_buf_b (
        .clk    (clk),
        .we     (we_b),
        .waddr  (k_reg[ADDR_W-1:0]),
        .wdata  (merge_data),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0_b),
        .rdata1 (rdata1_b)
    );

    assign status.sorted    = sorted_reg;
    assign status.count_le1 = (count_reg < CNT_W'(2));
    assign status.pair_last = ((k_reg + CNT_W'(1)) == hi_reg);
    assign status.lo_end    = (lo_2w >= count_ext);
    assign status.width_end = (width_2x >= count_ext);
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule
`default_nettype wire

@@ hdl/merge_sort_engine.sv @@
// Top level of the merge sort engine: controller, datapath and port checks.
// Depends on mse_pkg, mse_ctrl, mse_datapath (and mse_ram through it).
//
//   Channel   Direction  tdata                 tlast        tuser
//   s_*       in         [31:0] value          -            [0] mode (1 = read)
//   m_*       out        [31:0] sorted_value   last         [0] error
//
// Input stays ready across loads. The first read of a set sorts it first: for n elements
// there are ceil(log2 n) passes, each taking every run pair through the single merge
// unit between a setup and a next state. Each read passes the issue and output states
// and the registered RAM read port, and waits while the output register is full.
// Reset clears the counters and flags only; the two element buffers are not cleared.
`default_nettype none
module merge_sort_engine
    import mse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] sorted_value
    output logic             m_tlast,
    output logic             m_tuser    // [0] error
);

    mse_cmd_t    cmd;
    mse_status_t status;

    mse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    mse_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_value (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // An error result carries a zero value and no last mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == '0) && !m_tlast)
    else $error("error result with nonzero value or last mark");

    // Loads and merge writes share buffer A's write port and must never meet.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.merge_step))
    else $error("load collided with a merge write");

    // No input is taken while the sort sequencer is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pair_setup || cmd.merge_step || cmd.pair_next || cmd.pass_next) |-> !s_tready)
    else $error("input ready during a sort pass");

    // A new result is only captured when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
    else $error("output register overwritten");

endmodule
`default_nettype wire
